// File: hw/rtl/msd_pkg.sv
package msd_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PTR_W    = CNT_W + 1;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [AW-1:0]    addr_t;

	typedef struct packed {
		logic load;
		logic start;
		logic prime;
		logic step;
		logic emit_prime;
		logic emit;
		logic clear;
	} msd_cmd_t;

	typedef struct packed {
		logic one_elem;
		logic run_end;
		logic pass_end;
		logic sort_end;
		logic emit_last;
	} msd_stat_t;

endpackage

// File: hw/rtl/msd_in_if.sv
interface msd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

// File: hw/rtl/msd_out_if.sv
interface msd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sorted_value;
	logic               final_res;
	logic               dropped;

	modport source (output valid, output sorted_value, output final_res, output dropped,
		input ready);
	modport sink (input valid, input sorted_value, input final_res, input dropped,
		output ready);
endinterface

// File: hw/rtl/msd_ctrl.sv
module msd_ctrl import msd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  msd_stat_t stat,
	output msd_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_START,
		S_RUN,
		S_MERGE,
		S_EMIT_PRIME,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_EMIT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = stat.one_elem ? S_EMIT_PRIME : S_RUN;
			end
			S_RUN: begin
				cmd.prime = 1'b1;
				state_d   = S_MERGE;
			end
			S_MERGE: begin
				cmd.step = 1'b1;
				if (stat.run_end) begin
					if (stat.pass_end && stat.sort_end) begin
						state_d = S_EMIT_PRIME;
					end else begin
						state_d = S_RUN;
					end
				end
			end
			S_EMIT_PRIME: begin
				cmd.emit_prime = 1'b1;
				state_d        = S_EMIT;
			end
			S_EMIT: begin
				if (out_ready) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						cmd.clear = 1'b1;
						state_d   = S_LOAD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

endmodule

// File: hw/rtl/msd_dpath.sv
module msd_dpath import msd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  msd_cmd_t                 cmd,
	input  logic signed [DATA_W-1:0] value,
	output msd_stat_t                stat,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     final_res,
	output logic                     dropped
);

	logic [DATA_W-1:0] mem0 [CAPACITY];
	logic [DATA_W-1:0] mem1 [CAPACITY];

	logic [DATA_W-1:0] m0_a_q, m0_b_q, m1_a_q, m1_b_q;

	cnt_t cnt_q;
	logic ovf_q;
	logic parity_q;
	ptr_t width_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;

	logic signed [DATA_W-1:0] rda, rdb, win;
	logic  full, a_has, b_has, take_a;
	ptr_t  n_ext, a_n, b_n, k_n, lo_w, lo_2w, mid_calc, hi_calc;
	addr_t ra, rb;
	logic  wr0, wr1;
	logic [DATA_W-1:0] wd0;

	assign n_ext = PTR_W'(cnt_q);
	assign full  = (cnt_q == CNT_W'(CAPACITY));

	assign rda = parity_q ? m1_a_q : m0_a_q;
	assign rdb = parity_q ? m1_b_q : m0_b_q;

	assign a_has  = (a_q < mid_q);
	assign b_has  = (b_q < hi_q);
	assign take_a = a_has && (!b_has || (rda > rdb));
	assign win    = take_a ? rda : rdb;
	assign a_n    = take_a ? a_q + 1'b1 : a_q;
	assign b_n    = take_a ? b_q : b_q + 1'b1;
	assign k_n    = k_q + 1'b1;

	assign lo_w     = lo_q + width_q;
	assign lo_2w    = lo_q + {width_q[PTR_W-2:0], 1'b0};
	assign mid_calc = (lo_w > n_ext) ? n_ext : lo_w;
	assign hi_calc  = (lo_2w > n_ext) ? n_ext : lo_2w;

	// idle reads stay on the current output word so it holds while stalled
	always_comb begin
		ra = k_q[AW-1:0];
		rb = b_q[AW-1:0];
		if (cmd.prime) begin
			ra = lo_q[AW-1:0];
			rb = mid_calc[AW-1:0];
		end else if (cmd.step || cmd.emit) begin
			ra = cmd.emit ? k_n[AW-1:0] : a_n[AW-1:0];
			rb = b_n[AW-1:0];
		end else if (cmd.emit_prime) begin
			ra = '0;
		end
	end

	assign wr0 = (cmd.load && !full) || (cmd.step && parity_q);
	assign wr1 = cmd.step && !parity_q;
	assign wd0 = cmd.load ? value : win;

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem0[cmd.load ? cnt_q[AW-1:0] : k_q[AW-1:0]] <= wd0;
		end
		m0_a_q <= mem0[ra];
		m0_b_q <= mem0[rb];
	end

	always_ff @(posedge clk) begin
		if (wr1) begin
			mem1[k_q[AW-1:0]] <= win;
		end
		m1_a_q <= mem1[ra];
		m1_b_q <= mem1[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			parity_q <= 1'b0;
			width_q  <= '0;
			lo_q     <= '0;
			mid_q    <= '0;
			hi_q     <= '0;
			a_q      <= '0;
			b_q      <= '0;
			k_q      <= '0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.start) begin
				width_q  <= PTR_W'(1);
				lo_q     <= '0;
				parity_q <= 1'b0;
			end
			if (cmd.prime) begin
				a_q   <= lo_q;
				b_q   <= mid_calc;
				mid_q <= mid_calc;
				hi_q  <= hi_calc;
				k_q   <= lo_q;
			end
			if (cmd.step) begin
				a_q <= a_n;
				b_q <= b_n;
				k_q <= k_n;
				if (stat.run_end) begin
					if (stat.pass_end) begin
						parity_q <= ~parity_q;
						width_q  <= {width_q[PTR_W-2:0], 1'b0};
						lo_q     <= '0;
					end else begin
						lo_q <= hi_q;
					end
				end
			end
			if (cmd.emit_prime) begin
				k_q <= '0;
			end
			if (cmd.emit) begin
				k_q <= k_n;
			end
			if (cmd.clear) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	assign stat.one_elem  = (cnt_q == CNT_W'(1));
	assign stat.run_end   = (k_n == hi_q);
	assign stat.pass_end  = (hi_q == n_ext);
	assign stat.sort_end  = ({width_q, 1'b0} >= {1'b0, n_ext});
	assign stat.emit_last = (k_q == n_ext - 1'b1);

	assign sorted_value = rda;
	assign final_res    = stat.emit_last;
	assign dropped      = ovf_q;

endmodule

// File: hw/rtl/merge_sort_descending.sv
// operation: words load one per cycle while the sender holds valid; after the last word, a start step, then
// ceil(log2 n) merge passes, each priming and merging every pair of runs, a step to prime the output,
// then words leave one per cycle while the receiver is ready
// the single merge unit reads two words and writes one word per cycle through the two memories;
// a new set is accepted only after the last sorted word of the previous set has left
// reset: clears the controller, element count and overflow flag; memories are not cleared
module merge_sort_descending import msd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	msd_in_if.sink    items,
	msd_out_if.source results
);

	msd_cmd_t  cmd;
	msd_stat_t stat;

	msd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_last   (items.last),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	msd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (items.value),
		.stat         (stat),
		.sorted_value (results.sorted_value),
		.final_res    (results.final_res),
		.dropped      (results.dropped)
	);

endmodule

// File: verif/tb_merge_sort_descending.sv
module tb_merge_sort_descending;
	timeunit 1ns;
	timeprecision 1ps;

	import msd_pkg::*;

	localparam int STALL_LIMIT = 6000;
	localparam int HOLD_CYCLES = 1500;
	localparam int PRINT_LIMIT = 30;

	typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE} value_mix_e;

	typedef struct {
		logic signed [31:0] value;
		logic               last;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               final_res;
		logic               dropped;
	} sorted_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               drv_valid = 1'b0;
	logic signed [31:0] drv_value = '0;
	logic               drv_last = 1'b0;
	logic               rcv_ready = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_arm = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	in_word_t           pending_words[$];
	logic signed [31:0] loaded_words[$];
	logic               spill_seen = 1'b0;
	sorted_word_t       sorted_expect[$];

	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int sets_done = 0;
	int spilled_sets = 0;

	msd_in_if  items_if();
	msd_out_if results_if();

	assign items_if.valid   = drv_valid;
	assign items_if.value   = drv_value;
	assign items_if.last    = drv_last;
	assign results_if.ready = rcv_ready;

	merge_sort_descending DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(string what, logic signed [31:0] got,
		logic signed [31:0] want);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("[%0t] mismatch on word %0d, %s: got %0d, expected %0d",
				$realtime, words_out, what, got, want);
	endtask

	// predictor: collect the set, sort descending when the last word arrives
	task automatic load_word(logic signed [31:0] v, logic is_last);
		logic signed [31:0] vals[$];
		logic signed [31:0] key;
		sorted_word_t w;
		int i;
		int j;
		words_in++;
		if (loaded_words.size() < CAPACITY)
			loaded_words.push_back(v);
		else
			spill_seen = 1'b1;
		if (is_last) begin
			vals = loaded_words;
			for (i = 1; i < vals.size(); i++) begin
				key = vals[i];
				j = i - 1;
				while (j >= 0 && vals[j] < key) begin
					vals[j + 1] = vals[j];
					j--;
				end
				vals[j + 1] = key;
			end
			for (i = 0; i < vals.size(); i++) begin
				w.sorted_value = vals[i];
				w.final_res = (i == vals.size() - 1);
				w.dropped = spill_seen;
				sorted_expect.push_back(w);
			end
			if (spill_seen)
				spilled_sets++;
			sets_done++;
			loaded_words.delete();
			spill_seen = 1'b0;
		end
	endtask

	task automatic check_word(logic signed [31:0] v, logic f, logic d);
		sorted_word_t want;
		if (sorted_expect.size() == 0) begin
			report_mismatch("word with nothing expected", v, 0);
		end else begin
			want = sorted_expect.pop_front();
			if (v !== want.sorted_value)
				report_mismatch("sorted_value", v, want.sorted_value);
			if (f !== want.final_res)
				report_mismatch("final_res", 32'(f), 32'(want.final_res));
			if (d !== want.dropped)
				report_mismatch("dropped", 32'(d), 32'(want.dropped));
		end
		words_out++;
	endtask

	// driver
	in_word_t next_word;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_value <= '0;
			drv_last <= 1'b0;
		end else begin
			if (drv_valid && items_if.ready)
				load_word(drv_value, drv_last);
			if (!drv_valid || items_if.ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = pending_words.pop_front();
					drv_valid <= 1'b1;
					drv_value <= next_word.value;
					drv_last <= next_word.last;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (results_if.valid && rcv_ready)
				check_word(results_if.sorted_value, results_if.final_res, results_if.dropped);
			rcv_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if ((drv_valid && items_if.ready) || (results_if.valid && rcv_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d words still expected",
				STALL_LIMIT, sorted_expect.size());
			$display("** merge_sort_descending: FAILED **");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value(value_mix_e mix);
		logic signed [31:0] v;
		case (mix)
			VAL_WIDE: begin
				v = $urandom;
			end
			VAL_NARROW: begin
				v = $signed($urandom_range(6)) - 3;
			end
			default: begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 0;
					3: v = -1;
					default: v = $urandom;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic add_word(logic signed [31:0] v, logic is_last);
		in_word_t w;
		w.value = v;
		w.last = is_last;
		pending_words.push_back(w);
	endtask

	task automatic add_set(int n);
		value_mix_e mix;
		int r;
		r = $urandom_range(99);
		mix = (r < 60) ? VAL_WIDE : (r < 80) ? VAL_NARROW : VAL_EDGE;
		for (int i = 0; i < n; i++)
			add_word(pick_value(mix), i == n - 1);
	endtask

	task automatic add_random_sets(int budget);
		int n;
		int r;
		while (budget > 0) begin
			r = $urandom_range(99);
			if (r < 70)
				n = $urandom_range(8, 1);
			else if (r < 88)
				n = $urandom_range(32, 9);
			else if (r < 94)
				n = CAPACITY;
			else
				n = $urandom_range(CAPACITY + 6, CAPACITY + 1);
			add_set(n);
			budget -= n;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_words.size() != 0 || drv_valid || sorted_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single words, extremes, ties, presorted orders, bit patterns
		set_idling(0, 0);
		add_word(32'h7fff_ffff, 1'b1);
		add_word(32'h8000_0000, 1'b1);
		add_word(0, 1'b0);
		add_word(-1, 1'b0);
		add_word(1, 1'b0);
		add_word(32'h8000_0000, 1'b0);
		add_word(32'h7fff_ffff, 1'b0);
		add_word(0, 1'b1);
		add_word(1, 1'b0);
		add_word(2, 1'b0);
		add_word(3, 1'b0);
		add_word(4, 1'b1);
		add_word(5, 1'b0);
		add_word(5, 1'b0);
		add_word(5, 1'b1);
		add_word(9, 1'b0);
		add_word(-9, 1'b1);
		add_word(32'haaaa_aaaa, 1'b0);
		add_word(32'h5555_5555, 1'b1);
		drain();

		set_idling(55, 0);
		add_random_sets(55);
		drain();

		set_idling(0, 55);
		add_random_sets(55);
		drain();

		set_idling(13, 13);
		add_random_sets(55);
		drain();

		// receiver holds off while a full set and an overfull set are offered
		set_idling(0, 0);
		hold_arm = 1'b1;
		@(negedge clk);
		hold_arm = 1'b0;
		add_set(CAPACITY);
		add_set(CAPACITY + 1);
		add_set(3);
		add_set(1);
		drain();

		set_idling(0, 0);
		add_random_sets(55);
		drain();

		repeat (40) @(negedge clk);
		$display("%0d words loaded in %0d sets (%0d overfull), %0d sorted words checked",
			words_in, sets_done, spilled_sets, words_out);
		if (errors == 0)
			$display("** merge_sort_descending: PASSED **");
		else
			$display("** merge_sort_descending: FAILED **");
		$finish;
	end

endmodule
